// ===== sv/integer_kth_root_fixed_point_macros.svh =====
// Assertion macros for the k-th root block.
`ifndef INTEGER_KTH_ROOT_FIXED_POINT_MACROS_SVH
`define INTEGER_KTH_ROOT_FIXED_POINT_MACROS_SVH

// a implies b in the same cycle, masked during reset
`define KRT_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("krt check failed");

// a implies b in the next cycle, masked during reset
`define KRT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("krt check failed");

// a implies b in the next cycle, always checked
`define KRT_ASSERT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("krt check failed");

`endif

// ===== sv/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Shared word types and constants for the k-th root pipeline.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int unsigned RootW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned DegW  = 3;

  typedef struct packed {
    logic [RootW-1:0] radicand;
    logic [DegW-1:0]  degree;
  } in_t;

  typedef struct packed {
    logic [RootW-1:0] root;
    logic             bad_degree;
  } out_t;

  // control that travels beside each word in the pipe
  typedef struct packed {
    logic            valid;
    logic            bad;
    logic [DegW-1:0] degree;
  } ctl_t;

  // binomial coefficients, rows 0 to 8
  localparam int unsigned BINOM [0:8][0:8] = '{
    '{1, 0,  0,  0,  0,  0,  0, 0, 0},
    '{1, 1,  0,  0,  0,  0,  0, 0, 0},
    '{1, 2,  1,  0,  0,  0,  0, 0, 0},
    '{1, 3,  3,  1,  0,  0,  0, 0, 0},
    '{1, 4,  6,  4,  1,  0,  0, 0, 0},
    '{1, 5, 10, 10,  5,  1,  0, 0, 0},
    '{1, 6, 15, 20, 15,  6,  1, 0, 0},
    '{1, 7, 21, 35, 35, 21,  7, 1, 0},
    '{1, 8, 28, 56, 70, 56, 28, 8, 1}
  };

endpackage

// ===== sv/krt_stage.sv =====
// ----------------------------------------------------------------------------
// krt_stage
// One result bit of the root search. Keeps y and its powers y^1..y^MAX,
// forms the trial powers of y + 2^BIT by binomial expansion (shifts and
// constant weights only), and keeps the trial bit when trial^k <= target.
// ----------------------------------------------------------------------------
module krt_stage #(
  parameter int unsigned MAX_DEGREE = 4,
  parameter int unsigned BIT        = 31
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  krt_pkg::ctl_t                              ctl_in,
  input  logic [krt_pkg::RootW-1:0]                  y_in,
  input  logic [MAX_DEGREE:1][32*MAX_DEGREE-1:0]     pw_in,
  input  logic [32*MAX_DEGREE-1:0]                   target_in,
  output krt_pkg::ctl_t                              ctl,
  output logic [krt_pkg::RootW-1:0]                  y,
  output logic [MAX_DEGREE:1][32*MAX_DEGREE-1:0]     pw,
  output logic [32*MAX_DEGREE-1:0]                   target
);

  localparam int unsigned PW = 32 * MAX_DEGREE;
  localparam int unsigned RW = krt_pkg::RootW;

  logic [MAX_DEGREE:1][PW-1:0] cand;
  logic [PW-1:0]               sel;
  logic                        keep;

  always_comb begin
    logic [MAX_DEGREE:0][PW-1:0] full;
    logic [PW-1:0]               acc;
    full[0] = PW'(1);
    for (int j = 1; j <= int'(MAX_DEGREE); j++) begin
      full[j] = pw_in[j];
    end
    for (int j = 1; j <= int'(MAX_DEGREE); j++) begin
      acc = full[j];
      for (int i = 1; i <= j; i++) begin
        acc = acc + PW'(krt_pkg::BINOM[j][i]) * (full[j-i] << (BIT * i));
      end
      cand[j] = acc;
    end
  end

  always_comb begin
    sel = '0;
    for (int j = 1; j <= int'(MAX_DEGREE); j++) begin
      if ({1'b0, ctl_in.degree} == 4'(j)) begin
        sel = cand[j];
      end
    end
    keep = (sel <= target_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl.bad    <= ctl_in.bad;
      ctl.degree <= ctl_in.degree;
      target     <= target_in;
      if (keep) begin
        y  <= y_in | (RW'(1) << BIT);
        pw <= cand;
      end else begin
        y  <= y_in;
        pw <= pw_in;
      end
    end
  end

endmodule

// ===== sv/integer_kth_root_fixed_point.sv =====
// Each accepted word passes through every stage register to its result word.
// Throughput: one word per cycle while the result side is not stalled; one pipeline stage per result bit.
// A stalled result freezes the whole pipe; the input side stalls with it.
// Reset (rst, synchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// integer_kth_root_fixed_point
// Floor k-th root of a 32-bit radicand as unsigned Q16.16, k = 2..MAX_DEGREE.
// ----------------------------------------------------------------------------
module integer_kth_root_fixed_point #(
  parameter int unsigned MAX_DEGREE = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  krt_pkg::in_t   cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output krt_pkg::out_t  res
);

  localparam int unsigned PW = 32 * MAX_DEGREE;
  localparam int unsigned NB = krt_pkg::RootW;

  krt_pkg::ctl_t                    ctl_c [0:NB];
  logic [NB-1:0]                    y_c   [0:NB];
  logic [MAX_DEGREE:1][PW-1:0]      pw_c  [0:NB];
  logic [PW-1:0]                    tg_c  [0:NB];
  logic                             en;

  assign en        = !(ctl_c[NB].valid && res_stall);
  assign cmd_stall = !en;

  // target = radicand * 2^(16k)
  always_comb begin
    ctl_c[0].valid  = cmd_valid;
    ctl_c[0].degree = cmd.degree;
    ctl_c[0].bad    = (cmd.degree < 3'd2) || ({1'b0, cmd.degree} > 4'(MAX_DEGREE));
    y_c[0]          = '0;
    pw_c[0]         = '0;
    tg_c[0]         = PW'(cmd.radicand) << (krt_pkg::FracW * cmd.degree);
  end

  for (genvar s = 0; s < NB; s++) begin : g_stage
    krt_stage #(
      .MAX_DEGREE (MAX_DEGREE),
      .BIT        (NB - 1 - s)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .ctl_in    (ctl_c[s]),
      .y_in      (y_c[s]),
      .pw_in     (pw_c[s]),
      .target_in (tg_c[s]),
      .ctl       (ctl_c[s+1]),
      .y         (y_c[s+1]),
      .pw        (pw_c[s+1]),
      .target    (tg_c[s+1])
    );
  end

  assign res_valid      = ctl_c[NB].valid;
  assign res.root       = ctl_c[NB].bad ? '0 : y_c[NB];
  assign res.bad_degree = ctl_c[NB].bad;

endmodule

// ===== sv/krt_checker.sv =====
// ----------------------------------------------------------------------------
// krt_checker
// Port-level checks on the k-th root block, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_kth_root_fixed_point_macros.svh"

module krt_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_stall,
  input logic          res_valid,
  input logic          res_stall,
  input krt_pkg::out_t res
);

  `KRT_ASSERT_NOW(a_bad_zero, clk, rst, res_valid && res.bad_degree, res.root == '0)
  `KRT_ASSERT_NOW(a_stall_src, clk, rst, cmd_stall, res_valid && res_stall)
  `KRT_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res))
  `KRT_ASSERT_ALWAYS(a_rst_empty, clk, rst, !res_valid)

endmodule

bind integer_kth_root_fixed_point krt_checker u_krt_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Floor k-th root block: directed corners, random words, random flow control.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MaxDeg   = 4;
  localparam int unsigned Latency  = 32;
  localparam int unsigned NumRand  = 600;
  localparam longint      CycLimit = 400000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_stall;
  krt_pkg::in_t  cmd = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  krt_pkg::out_t res;

  krt_pkg::out_t root_q[$];
  int     n_err = 0;
  int     n_sent = 0;
  int     n_got = 0;
  int     n_bad = 0;
  longint cyc = 0;

  always #6 clk = ~clk;

  integer_kth_root_fixed_point #(.MAX_DEGREE(MaxDeg)) u_top (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  // y^k at full width for k up to MaxDeg
  function automatic logic [127:0] pow_k(input logic [31:0] y, input int unsigned k);
    logic [127:0] p;
    p = 128'd1;
    for (int i = 0; i < k; i++) p = p * {96'd0, y};
    return p;
  endfunction

  function automatic krt_pkg::out_t floor_root(input krt_pkg::in_t w);
    krt_pkg::out_t o;
    logic [127:0]  goal;
    logic [31:0]   y, c;
    int unsigned   k;
    o = '0;
    k = {29'd0, w.degree};
    if (k < 2 || k > MaxDeg) begin
      o.bad_degree = 1'b1;
      return o;
    end
    goal = {96'd0, w.radicand} << (16 * k);
    y = '0;
    for (int b = 31; b >= 0; b--) begin
      c = y | (32'd1 << b);
      if (pow_k(c, k) <= goal) y = c;
    end
    o.root = y;
    return o;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, exp, n_got);
    n_err++;
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycLimit) begin
      $display("timeout after %0d cycles", cyc);
      $display("tb: errors");
      $finish;
    end
  end

  // result checker and receiver stall
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (root_q.size() == 0) begin
          $display("unexpected result word %h", res);
          n_err++;
        end else begin
          krt_pkg::out_t e;
          e = root_q.pop_front();
          if (res.root !== e.root) report("root", res.root, e.root);
          if (res.bad_degree !== e.bad_degree) begin
            report("bad_degree", {31'd0, res.bad_degree}, {31'd0, e.bad_degree});
          end
          n_got++;
        end
        stall_left = (n_got % 150 < 40) ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  bit sender_idle_on = 1'b1;

  task automatic send_word(input logic [31:0] a, input logic [2:0] k);
    krt_pkg::in_t w;
    int           gap;
    w.radicand = a;
    w.degree   = k;
    gap = sender_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    root_q.push_back(floor_root(w));
    n_sent++;
    if (k < 2 || k > MaxDeg) n_bad++;
  endtask

  task automatic go_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_corners();
    logic [31:0] vals[6] = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1000000};
    foreach (vals[i]) for (int k = 2; k <= 4; k++) send_word(vals[i], k[2:0]);
    send_word(32'h1234_5678, 3'd0);
    send_word(32'hFFFF_FFFF, 3'd1);
    send_word(32'd0, 3'd5);
    send_word(32'd81, 3'd7);
    go_idle();
  endtask

  // sender holds off until every expected word has come back
  task automatic test_drain();
    while (root_q.size() != 0) @(posedge clk);
    send_word(32'd65536, 3'd4);
    go_idle();
  endtask

  task automatic test_random();
    logic [31:0] a;
    logic [2:0]  k;
    for (int i = 0; i < NumRand; i++) begin
      sender_idle_on = !(i % 200 < 50);
      case ($urandom_range(0, 3))
        0: a = $urandom_range(0, 1000);
        1: a = $urandom >> $urandom_range(0, 31);
        2: a = ~($urandom_range(0, 255));
        default: a = $urandom;
      endcase
      k = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(2, 4));
      send_word(a, k);
    end
    sender_idle_on = 1'b1;
    go_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_drain();
    test_random();
    while (root_q.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
    $display("sent %0d words (%0d with bad degree), checked %0d results", n_sent, n_bad, n_got);
    $display("degrees 0..7, corner radicands, random stalls on both sides");
    if (n_err == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/krt_pkg.sv
sv/krt_stage.sv
sv/integer_kth_root_fixed_point.sv
sv/krt_checker.sv
sim/tb.sv
